>>> design/glyph_framebuffer_dirty_page_flush_unit_macros.svh
// Assertion macros shared by the checker of the frame store flush unit
`ifndef GLYPH_FRAMEBUFFER_DIRTY_PAGE_FLUSH_UNIT_MACROS_SVH
`define GLYPH_FRAMEBUFFER_DIRTY_PAGE_FLUSH_UNIT_MACROS_SVH

// Same-cycle implication, off during reset
`define GFD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define GFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/gfd_pkg.sv
// Shared types, codes and the 5x7 glyph ROM of the frame store flush unit
package gfd_pkg;

  localparam logic [2:0] ACT_CLEAR     = 3'd0;
  localparam logic [2:0] ACT_PIXEL     = 3'd1;
  localparam logic [2:0] ACT_GLYPH_XY  = 3'd2;
  localparam logic [2:0] ACT_GLYPH_CUR = 3'd3;
  localparam logic [2:0] ACT_SET_CUR   = 3'd4;
  localparam logic [2:0] ACT_FLUSH     = 3'd5;

  localparam logic [1:0] KIND_IDLE = 2'd0;
  localparam logic [1:0] KIND_CMD  = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  localparam logic [7:0] CMD_BYTE0 = 8'h20;
  localparam logic [7:0] CMD_BYTE1 = 8'h02;
  localparam logic [7:0] CMD_PAGE  = 8'hB0;
  localparam logic [7:0] CMD_BYTE3 = 8'h00;
  localparam logic [7:0] CMD_BYTE4 = 8'h10;

  localparam logic [7:0] CURSOR_STEP = 8'd6;
  localparam logic [8:0] GLYPH_WIDTH = 9'd5;
  localparam logic [7:0] PAGE_ROWS   = 8'd8;
  localparam logic [3:0] SLOT_LAST   = 4'd9;   // 5 columns x 2 pages
  localparam logic [39:0] PIXEL_GLYPH = 40'h00_0000_0001;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic rmw_rd;
    logic rmw_wr;
    logic slot_step;
    logic fl_rd;
    logic fl_cap;
    logic fl_col_step;
    logic out_cmd;
    logic out_word;
    logic out_idle;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic slot_active;
    logic slot_last;
    logic dirty_any;
    logic byte_last;
    logic word_last;
    logic out_busy;
  } sts_t;

  // Columns packed {c4,c3,c2,c1,c0}, bit 0 is the top row
  localparam logic [39:0] GLYPH_ROM [95] = '{
    40'h0000000000, 40'h00005F0000, 40'h0003000300, 40'h147F147F14, 40'h122A7F2A24,
    40'h6264081323, 40'h5022554936, 40'h0000030500, 40'h0041221C00, 40'h001C224100,
    40'h14083E0814, 40'h08083E0808, 40'h0000305000, 40'h0808080808, 40'h0000606000,
    40'h0204081020, 40'h3E4549513E, 40'h00407F4200, 40'h4649516142, 40'h314B454121,
    40'h107F121418, 40'h3945454527, 40'h3049494A3C, 40'h0305097101, 40'h3649494936,
    40'h3E49494926, 40'h0000363600, 40'h0000365600, 40'h4122140800, 40'h1414141414,
    40'h0008142241, 40'h0609510102, 40'h3E41794932, 40'h7E1111117E, 40'h364949497F,
    40'h224141413E, 40'h1C2241417F, 40'h414949497F, 40'h010109097F, 40'h7A4949413E,
    40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h412214087F, 40'h404040407F,
    40'h7F0204027F, 40'h7F1008047F, 40'h3E4141413E, 40'h060909097F, 40'h5E2151413E,
    40'h462919097F, 40'h3149494946, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4030403F, 40'h6314081463, 40'h0304780403, 40'h4345495161, 40'h41417F0000,
    40'h2010080402, 40'h00007F4141, 40'h0402010204, 40'h4040404040, 40'h0000020100,
    40'h7854545420, 40'h384444487F, 40'h2044444438, 40'h7F48444438, 40'h1854545438,
    40'h0201097E08, 40'h3C54545408, 40'h780404087F, 40'h00407D4400, 40'h007D848040,
    40'h004428107F, 40'h0040407F00, 40'h78047C0478, 40'h780404087C, 40'h3844444438,
    40'h081414147C, 40'h7C18141408, 40'h080404087C, 40'h2054545448, 40'h2040443F04,
    40'h7C2040403C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h3C5050500C,
    40'h444C546444, 40'h0041360800, 40'h00007F0000, 40'h0008364100, 40'h081C2A0808
  };

  // Printable codes only; anything else draws nothing
  function automatic logic [39:0] glyph_bits(input logic [7:0] code);
    logic [6:0] idx;
    idx = 7'(code - 8'd32);
    if (code < 8'd32 || code > 8'd126) begin
      return 40'd0;
    end
    return GLYPH_ROM[idx];
  endfunction

endpackage

>>> design/gfd_ram.sv
// Generic single-port RAM with registered read
module gfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/gfd_ctrl.sv
// Controller state machine: sequences clear sweeps, read-modify-writes and flushes
module gfd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [2:0]    in_action,
  input  gfd_pkg::sts_t sts,
  output logic          in_ready,
  output gfd_pkg::cmd_t cmd
);
  import gfd_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RMW_RD, S_RMW_WR, S_FL_IDLE, S_FL_CMD, S_FL_RD, S_FL_CAP, S_FL_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;   // store is swept to zero after reset
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          priority case (in_action)
            ACT_CLEAR:                             state_nxt = S_CLEAR;
            ACT_PIXEL, ACT_GLYPH_XY, ACT_GLYPH_CUR: state_nxt = S_RMW_RD;
            ACT_FLUSH: state_nxt = sts.dirty_any ? S_FL_CMD : S_FL_IDLE;
            default:                               state_nxt = S_IDLE;
          endcase
        end
      end
      S_RMW_RD: begin
        if (sts.slot_active) begin
          cmd.rmw_rd = 1'b1;
          state_nxt  = S_RMW_WR;
        end else if (sts.slot_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.slot_step = 1'b1;
        end
      end
      S_RMW_WR: begin
        cmd.rmw_wr = 1'b1;
        if (sts.slot_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.slot_step = 1'b1;
          state_nxt     = S_RMW_RD;
        end
      end
      S_FL_IDLE: begin
        if (!sts.out_busy) begin
          cmd.out_idle = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_FL_CMD: begin
        if (!sts.out_busy) begin
          cmd.out_cmd = 1'b1;
          state_nxt   = S_FL_RD;
        end
      end
      S_FL_RD: begin
        cmd.fl_rd = 1'b1;
        state_nxt = S_FL_CAP;
      end
      S_FL_CAP: begin
        cmd.fl_cap = 1'b1;
        if (sts.byte_last) begin
          state_nxt = S_FL_OUT;
        end else begin
          cmd.fl_col_step = 1'b1;
          state_nxt       = S_FL_RD;
        end
      end
      S_FL_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_word = 1'b1;
          if (sts.word_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.fl_col_step = 1'b1;
            state_nxt       = S_FL_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> design/gfd_datapath.sv
// Datapath: frame store, glyph slot addressing, cursor, dirty mask and result register
module gfd_datapath #(
  parameter int DISPLAY_WIDTH = 128,
  parameter int PAGE_COUNT    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [2:0]    in_action,
  input  logic [7:0]    in_x_coord,
  input  logic [7:0]    in_y_coord,
  input  logic [7:0]    in_char_code,
  input  gfd_pkg::cmd_t cmd,
  output gfd_pkg::sts_t sts,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [1:0]    out_kind,
  output logic [2:0]    out_page_number,
  output logic [3:0]    out_word_index,
  output logic [63:0]   out_payload,
  output logic          out_last
);
  import gfd_pkg::*;

  localparam int DEPTH = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WORDS = (DISPLAY_WIDTH + 7) / 8;
  localparam int COL_W = $clog2(WORDS * 8);
  localparam int ROWS  = PAGE_COUNT * 8;
  localparam logic [7:0] ALL_DIRTY = 8'((9'd1 << PAGE_COUNT) - 9'd1);

  logic [7:0]       x_r, y_r, cx_r, cy_r, dirty_r;
  logic [39:0]      glyph_r;
  logic [3:0]       slot_r;
  logic [AW-1:0]    clr_r;
  logic [2:0]       page_r;
  logic [COL_W-1:0] col_r;
  logic [63:0]      word_r;

  logic             out_valid_r, out_last_r;
  logic [1:0]       out_kind_r;
  logic [2:0]       out_page_r;
  logic [3:0]       out_word_r;
  logic [63:0]      out_payload_r;

  // current glyph slot: column slot_r/2, upper or lower page by slot_r[0]
  logic [2:0]    slot_c;
  logic [7:0]    xc, blk, colbits, mask, rd_data, fl_byte, nx;
  logic [2:0]    sh, slot_pg, first_dirty;
  logic          on_screen;
  logic [AW-1:0] slot_addr, fl_addr, ram_addr;
  logic          ram_we;
  logic [7:0]    ram_wdata;

  assign slot_c    = slot_r[3:1];
  assign sh        = y_r[2:0];
  assign xc        = x_r + 8'(slot_c);
  assign blk       = slot_r[0] ? (y_r + PAGE_ROWS) : y_r;
  assign colbits   = glyph_r[slot_c*8 +: 8];
  assign mask      = slot_r[0] ? (colbits >> (4'd8 - {1'b0, sh})) : 8'(colbits << sh);
  assign slot_pg   = blk[5:3];
  assign on_screen = ({1'b0, xc} < 9'(DISPLAY_WIDTH)) && (blk < 8'(ROWS));
  assign slot_addr = AW'(32'(slot_pg) * DISPLAY_WIDTH) + AW'(xc);
  assign fl_addr   = AW'(32'(page_r) * DISPLAY_WIDTH) + AW'(col_r);
  assign fl_byte   = (32'(col_r) < DISPLAY_WIDTH) ? rd_data : 8'd0;
  assign nx        = cx_r + CURSOR_STEP;

  always_comb begin
    first_dirty = 3'd0;
    for (int p = PAGE_COUNT - 1; p >= 0; p--) begin
      if (dirty_r[p]) first_dirty = 3'(p);
    end
  end

  always_comb begin
    priority if (cmd.clr_wr) begin
      ram_addr = clr_r;
    end else if (cmd.fl_rd) begin
      ram_addr = fl_addr;
    end else begin
      ram_addr = slot_addr;
    end
  end
  assign ram_we    = cmd.clr_wr | cmd.rmw_wr;
  assign ram_wdata = cmd.clr_wr ? 8'd0 : (rd_data | mask);

  gfd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r     <= 8'd0;
      cx_r        <= 8'd0;
      cy_r        <= 8'd0;
      clr_r       <= '0;
      slot_r      <= 4'd0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_r <= (clr_r == AW'(DEPTH - 1)) ? '0 : clr_r + 1'b1;
      end
      if (cmd.load) begin
        slot_r <= 4'd0;
        unique case (in_action)
          ACT_CLEAR: dirty_r <= ALL_DIRTY;
          ACT_GLYPH_CUR: begin
            if ({1'b0, nx} + GLYPH_WIDTH >= 9'(DISPLAY_WIDTH)) begin
              cx_r <= 8'd0;
              cy_r <= cy_r + PAGE_ROWS;
            end else begin
              cx_r <= nx;
            end
          end
          ACT_SET_CUR: begin
            cx_r <= in_x_coord;
            cy_r <= in_y_coord;
          end
          default: ;
        endcase
      end
      if (cmd.slot_step) slot_r <= slot_r + 4'd1;
      if (cmd.rmw_wr) dirty_r[slot_pg] <= 1'b1;
      if (cmd.out_cmd) col_r <= '0;
      if (cmd.fl_col_step) col_r <= col_r + 1'b1;
      if (cmd.out_word && sts.word_last) dirty_r[page_r] <= 1'b0;
      if (cmd.out_idle || cmd.out_cmd || cmd.out_word) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r <= first_dirty;
      unique case (in_action)
        ACT_GLYPH_CUR: begin
          x_r     <= cx_r;
          y_r     <= cy_r;
          glyph_r <= glyph_bits(in_char_code);
        end
        ACT_PIXEL: begin
          x_r     <= in_x_coord;
          y_r     <= in_y_coord;
          glyph_r <= PIXEL_GLYPH;
        end
        default: begin
          x_r     <= in_x_coord;
          y_r     <= in_y_coord;
          glyph_r <= glyph_bits(in_char_code);
        end
      endcase
    end
    if (cmd.fl_cap) word_r <= {fl_byte, word_r[63:8]};
    if (cmd.out_idle) begin
      out_kind_r    <= KIND_IDLE;
      out_page_r    <= 3'd0;
      out_word_r    <= 4'd0;
      out_payload_r <= 64'd0;
      out_last_r    <= 1'b1;
    end
    if (cmd.out_cmd) begin
      out_kind_r    <= KIND_CMD;
      out_page_r    <= page_r;
      out_word_r    <= 4'd0;
      out_payload_r <= {24'd0, CMD_BYTE4, CMD_BYTE3, CMD_PAGE | {5'd0, page_r},
                        CMD_BYTE1, CMD_BYTE0};
      out_last_r    <= 1'b0;
    end
    if (cmd.out_word) begin
      out_kind_r    <= KIND_DATA;
      out_page_r    <= page_r;
      out_word_r    <= 4'(col_r >> 3);
      out_payload_r <= word_r;
      out_last_r    <= sts.word_last;
    end
  end

  assign sts.clr_last    = (clr_r == AW'(DEPTH - 1));
  assign sts.slot_active = on_screen && (mask != 8'd0);
  assign sts.slot_last   = (slot_r == SLOT_LAST);
  assign sts.dirty_any   = (dirty_r != 8'd0);
  assign sts.byte_last   = (col_r[2:0] == 3'b111);
  assign sts.word_last   = (col_r == COL_W'(WORDS * 8 - 1));
  assign sts.out_busy    = out_valid_r;

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_page_number = out_page_r;
  assign out_word_index  = out_word_r;
  assign out_payload     = out_payload_r;
  assign out_last        = out_last_r;

endmodule

>>> design/glyph_framebuffer_dirty_page_flush_unit.sv
// Top level of the page-mode frame store with 5x7 text and dirty-page flush
//
// Input channel (in_valid/in_ready) takes one action per transaction: clear,
// pixel, glyph at x/y, glyph at cursor, set cursor or flush. Result channel
// (out_valid/out_ready) carries flush results: one command word then one data
// word per eight columns, out_last on the final one; an empty dirty mask gives
// a single idle result with out_last set.
// Transactions go one at a time through a single-port frame store:
//   set cursor and unused actions: taken in the idle state with no further step.
//   pixel: it walks the same ten slots as a glyph.
//   glyph: a read and a write per touched byte over the ten slots,
//   5 columns x 2 pages; a skipped slot only steps on to the next one.
//   clear: the whole store is zeroed a byte a cycle.
//   flush: a command word, then each byte is read and captured, eight to a data word.
// After reset the same clearing pass runs over DISPLAY_WIDTH*PAGE_COUNT bytes (1024
// by default) with in_ready low. The result sits in an output register; while the
// receiver stalls, a flush holds at its next result and takes no input, and the
// next flush waits until the register has emptied.
module glyph_framebuffer_dirty_page_flush_unit #(
  parameter int DISPLAY_WIDTH = 128,
  parameter int PAGE_COUNT    = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_x_coord,
  input  logic [7:0]  in_y_coord,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_page_number,
  output logic [3:0]  out_word_index,
  output logic [63:0] out_payload,
  output logic        out_last
);
  import gfd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .sts       (sts),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  gfd_datapath #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .PAGE_COUNT    (PAGE_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_action),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .in_char_code    (in_char_code),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_page_number (out_page_number),
    .out_word_index  (out_word_index),
    .out_payload     (out_payload),
    .out_last        (out_last)
  );

endmodule

>>> design/gfd_checker.sv
// Port-level checker for the frame store flush unit, bound to the top level
`include "glyph_framebuffer_dirty_page_flush_unit_macros.svh"

module gfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [2:0]  out_page_number,
  input logic [63:0] out_payload,
  input logic        out_last
);
  import gfd_pkg::*;

  `GFD_ASSERT_NEXT(a_flush_blocks_input, in_valid && in_ready && in_action == ACT_FLUSH, !in_ready, "input taken during a flush")
  `GFD_ASSERT_SAME(a_idle_shape, out_valid && out_kind == KIND_IDLE, out_last && out_payload == 64'd0, "malformed idle result")
  `GFD_ASSERT_SAME(a_cmd_page, out_valid && out_kind == KIND_CMD, !out_last && out_payload[23:16] == (CMD_PAGE | {5'd0, out_page_number}), "command page mismatch")
  `GFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload), "stalled result changed")

endmodule

bind glyph_framebuffer_dirty_page_flush_unit gfd_checker u_gfd_checker (.*);
